// ===== design/hcbd_pkg.sv =====
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int unsigned LineLimitDefault = 16;
  localparam int unsigned SizeBitsDefault  = 32;

  localparam logic [7:0] CharLf = 8'h0a;
  localparam logic [7:0] CharCr = 8'h0d;

  // result kinds
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindByte  = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;
  localparam logic [1:0] KindError = 2'd3;

  // error codes
  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrSizeLine = 2'd1;
  localparam logic [1:0] ErrCrlf     = 2'd2;
  localparam logic [1:0] ErrEarlyEnd = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;
  } out_beat_t;

  // handshake between the input register and the decode core
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

// ===== design/hcbd_if.sv =====
`timescale 1ns / 1ps

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [1:0] error_code;

  modport source (output valid, output kind, output out_byte, output error_code, input ready);
  modport sink (input valid, input kind, input out_byte, input error_code, output ready);
endinterface

// ===== design/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps

// Chunked body decoder: takes one body beat (a byte or a stream-end mark) and
// gives exactly one result beat for it: nothing, a payload byte, body
// complete, or a sticky error with its code. Sustained rate is one beat per
// clock while neither side stalls; either side is free to stall. A beat passes
// an input register, the single-pass next-state and result logic, and the
// result register. The rate is set by the parser state loop, which updates
// once per beat in that single pass.
module http_chunked_body_decoder #(
  parameter int unsigned LINE_LIMIT = hcbd_pkg::LineLimitDefault,
  parameter int unsigned SIZE_BITS  = hcbd_pkg::SizeBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbd_in_if.sink     in_i,
  hcbd_out_if.source  out_o
);
  import hcbd_pkg::*;

  in_beat_t   beat;
  logic       beat_valid;
  stage_ctl_t core_ctl;

  hcbd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (core_ctl.take),
    .valid_o (beat_valid),
    .beat_o  (beat)
  );

  hcbd_core #(
    .LINE_LIMIT (LINE_LIMIT),
    .SIZE_BITS  (SIZE_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .valid_i (beat_valid),
    .ctl_o   (core_ctl),
    .out_o   (out_o)
  );

endmodule

// ===== design/hcbd_in_reg.sv =====
`timescale 1ns / 1ps

module hcbd_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  hcbd_in_if.sink             in_i,
  input  logic                take_i,
  output logic                valid_o,
  output hcbd_pkg::in_beat_t  beat_o
);
  import hcbd_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign valid_d    = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q.in_byte    <= in_i.in_byte;
      beat_q.stream_end <= in_i.stream_end;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== design/hcbd_core.sv =====
`timescale 1ns / 1ps

module hcbd_core #(
  parameter int unsigned LINE_LIMIT = hcbd_pkg::LineLimitDefault,
  parameter int unsigned SIZE_BITS  = hcbd_pkg::SizeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hcbd_pkg::in_beat_t   beat_i,
  input  logic                 valid_i,
  output hcbd_pkg::stage_ctl_t ctl_o,
  hcbd_out_if.source           out_o
);
  import hcbd_pkg::*;

  localparam int unsigned CW = $clog2(LINE_LIMIT);
  localparam logic [CW-1:0] CharMax = CW'(LINE_LIMIT - 1);

  typedef enum logic [2:0] {
    PhLine = 3'd0,
    PhData = 3'd1,
    PhCrlf = 3'd2,
    PhDone = 3'd3,
    PhErr1 = 3'd4,
    PhErr2 = 3'd5,
    PhErr3 = 3'd6
  } phase_e;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    // bit 4 set means not a hex digit
    logic [4:0] r;
    r = 5'h10;
    if (b >= "0" && b <= "9") r = {1'b0, 4'(b - "0")};
    else if (b >= "a" && b <= "f") r = {1'b0, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") r = {1'b0, 4'(b - "A" + 8'd10)};
    return r;
  endfunction

  phase_e         phase_q, phase_d;
  logic [CW-1:0]  chars_q, chars_d;
  logic           pcr_q, pcr_d;
  logic           bad_q, bad_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;
  logic           crlf_q, crlf_d;

  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, res;
  logic      take;
  logic      too_long;
  logic [4:0] dig;
  logic [7:0] b;

  assign b    = beat_i.in_byte;
  assign dig  = hex_digit(b);
  assign take = valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    phase_d  = phase_q;
    chars_d  = chars_q;
    pcr_d    = pcr_q;
    bad_d    = bad_q;
    rem_d    = rem_q;
    crlf_d   = crlf_q;
    too_long = 1'b0;
    res      = '{kind: KindNone, out_byte: 8'h00, error_code: ErrNone};

    unique case (phase_q)
      PhDone: res.kind = KindDone;
      PhErr1: res = '{kind: KindError, out_byte: 8'h00, error_code: ErrSizeLine};
      PhErr2: res = '{kind: KindError, out_byte: 8'h00, error_code: ErrCrlf};
      PhLine, PhData, PhCrlf: begin
        if (beat_i.stream_end) begin
          phase_d = PhErr3;
          res     = '{kind: KindError, out_byte: 8'h00, error_code: ErrEarlyEnd};
        end else if (phase_q == PhLine) begin
          if (b == CharLf) begin
            if (chars_q == '0 || bad_q) begin
              phase_d = PhErr1;
              res     = '{kind: KindError, out_byte: 8'h00, error_code: ErrSizeLine};
            end else if (rem_q == '0) begin
              phase_d  = PhDone;
              res.kind = KindDone;
            end else begin
              chars_d = '0;
              pcr_d   = 1'b0;
              phase_d = PhData;
            end
          end else begin
            // a cr not followed by lf counts as a bad character
            if (pcr_q) begin
              pcr_d = 1'b0;
              bad_d = 1'b1;
              if (chars_d >= CharMax) too_long = 1'b1;
              else chars_d = chars_d + CW'(1);
            end
            if (!too_long) begin
              if (b == CharCr) begin
                pcr_d = 1'b1;
              end else begin
                if (chars_d >= CharMax) too_long = 1'b1;
                else chars_d = chars_d + CW'(1);
                if (dig[4]) begin
                  bad_d = 1'b1;
                end else if (!bad_d) begin
                  if (|rem_q[SIZE_BITS-1 -: 4]) bad_d = 1'b1;
                  else rem_d = {rem_q[SIZE_BITS-5:0], dig[3:0]};
                end
              end
            end
            if (too_long) begin
              phase_d = PhErr1;
              res     = '{kind: KindError, out_byte: 8'h00, error_code: ErrSizeLine};
            end
          end
        end else if (phase_q == PhData) begin
          rem_d = rem_q - SIZE_BITS'(1);
          if (rem_d == '0) begin
            phase_d = PhCrlf;
            crlf_d  = 1'b0;
          end
          res = '{kind: KindByte, out_byte: b, error_code: ErrNone};
        end else begin
          if (b != (crlf_q ? CharLf : CharCr)) begin
            phase_d = PhErr2;
            res     = '{kind: KindError, out_byte: 8'h00, error_code: ErrCrlf};
          end else if (!crlf_q) begin
            crlf_d = 1'b1;
          end else begin
            crlf_d  = 1'b0;
            chars_d = '0;
            pcr_d   = 1'b0;
            bad_d   = 1'b0;
            rem_d   = '0;
            phase_d = PhLine;
          end
        end
      end
      default: begin
        phase_d = PhErr3;
        res     = '{kind: KindError, out_byte: 8'h00, error_code: ErrEarlyEnd};
      end
    endcase
  end

  assign out_valid_d = take || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLine;
      chars_q     <= '0;
      pcr_q       <= 1'b0;
      bad_q       <= 1'b0;
      rem_q       <= '0;
      crlf_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q <= phase_d;
        chars_q <= chars_d;
        pcr_q   <= pcr_d;
        bad_q   <= bad_d;
        rem_q   <= rem_d;
        crlf_q  <= crlf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign ctl_o.valid      = out_valid_q;
  assign ctl_o.take       = take;
  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.out_byte   = out_q.out_byte;
  assign out_o.error_code = out_q.error_code;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hcbd_pkg::*;

  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned LineMax    = LineLimitDefault - 1;
  localparam int unsigned SizeBits   = SizeBitsDefault;
  localparam int unsigned BodyBeats  = 1860;

  typedef enum logic [2:0] {
    PhLine  = 3'd0,
    PhData  = 3'd1,
    PhCrlf  = 3'd2,
    PhDone  = 3'd3,
    PhErr1  = 3'd4,
    PhErr2  = 3'd5,
    PhErr3  = 3'd6
  } parse_phase_e;

  // how the body ends
  typedef enum int {
    EndZeroChunk,
    EndZeroPadded,
    EndBadHex,
    EndEmptyLine,
    EndOverflow,
    EndLongLine,
    EndStrayCr,
    EndMissingCrlf,
    EndCloseInLine,
    EndCloseInData,
    EndCloseInCrlf
  } body_end_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();

  http_chunked_body_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  in_beat_t  body_q[$];
  out_beat_t result_q[$];

  // decoder state as predicted
  parse_phase_e            ph = PhLine;
  logic [4:0]              char_cnt = '0;
  logic                    cr_seen = 1'b0;
  logic                    size_bad = 1'b0;
  logic [SizeBits-1:0]     size_acc = '0;
  logic                    crlf_lf = 1'b0;

  int unsigned mismatches = 0;
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;
  in_beat_t    cur_beat;

  function automatic out_beat_t raise_error(logic [1:0] code);
    out_beat_t r;
    r.kind = KindError;
    r.out_byte = 8'h00;
    r.error_code = code;
    if (code == ErrSizeLine) ph = PhErr1;
    else if (code == ErrCrlf) ph = PhErr2;
    else ph = PhErr3;
    return r;
  endfunction

  function automatic out_beat_t decode_beat(logic [7:0] b, logic fin);
    out_beat_t r;
    logic [3:0] dv;
    logic       dok;
    logic       too_long;
    r.kind = KindNone;
    r.out_byte = 8'h00;
    r.error_code = ErrNone;
    too_long = 1'b0;
    dok = 1'b1;
    dv = '0;
    case (ph)
      PhDone: r.kind = KindDone;
      PhErr1: begin
        r.kind = KindError;
        r.error_code = ErrSizeLine;
      end
      PhErr2: begin
        r.kind = KindError;
        r.error_code = ErrCrlf;
      end
      PhLine, PhData, PhCrlf: begin
        if (fin) begin
          r = raise_error(ErrEarlyEnd);
        end else if (ph == PhLine) begin
          if (b == CharLf) begin
            if (char_cnt == 0 || size_bad) begin
              r = raise_error(ErrSizeLine);
            end else if (size_acc == 0) begin
              ph = PhDone;
              r.kind = KindDone;
            end else begin
              char_cnt = '0;
              cr_seen = 1'b0;
              ph = PhData;
            end
          end else begin
            // a cr not followed by lf turns into a bad line character
            if (cr_seen) begin
              cr_seen = 1'b0;
              size_bad = 1'b1;
              if (char_cnt >= LineMax) too_long = 1'b1;
              else char_cnt++;
            end
            if (!too_long) begin
              if (b == CharCr) begin
                cr_seen = 1'b1;
              end else if (char_cnt >= LineMax) begin
                too_long = 1'b1;
              end else begin
                char_cnt++;
                if (b >= "0" && b <= "9") dv = 4'(b - "0");
                else if (b >= "a" && b <= "f") dv = 4'(b - "a" + 10);
                else if (b >= "A" && b <= "F") dv = 4'(b - "A" + 10);
                else dok = 1'b0;
                if (!dok) begin
                  size_bad = 1'b1;
                end else if (!size_bad) begin
                  if (size_acc > ({SizeBits{1'b1}} >> 4)) size_bad = 1'b1;
                  else size_acc = {size_acc[SizeBits-5:0], dv};
                end
              end
            end
            if (too_long) r = raise_error(ErrSizeLine);
          end
        end else if (ph == PhData) begin
          size_acc = size_acc - 1'b1;
          if (size_acc == 0) begin
            ph = PhCrlf;
            crlf_lf = 1'b0;
          end
          r.kind = KindByte;
          r.out_byte = b;
        end else begin
          if (!crlf_lf) begin
            if (b != CharCr) r = raise_error(ErrCrlf);
            else crlf_lf = 1'b1;
          end else if (b != CharLf) begin
            r = raise_error(ErrCrlf);
          end else begin
            crlf_lf = 1'b0;
            char_cnt = '0;
            cr_seen = 1'b0;
            size_bad = 1'b0;
            size_acc = '0;
            ph = PhLine;
          end
        end
      end
      default: r = raise_error(ErrEarlyEnd);
    endcase
    return r;
  endfunction

  task automatic put(logic [7:0] b, logic fin);
    in_beat_t t;
    t.in_byte = b;
    t.stream_end = fin;
    body_q.push_back(t);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    if ($urandom_range(0, 1) == 0) return 8'("A" + n - 10);
    return 8'("a" + n - 10);
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return CharCr;
      1: return CharLf;
      2: return 8'h00;
      3: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")
               || c == CharCr || c == CharLf);
    return c;
  endfunction

  task automatic put_size_line(int unsigned v, int unsigned digits, bit with_cr);
    for (int i = int'(digits) - 1; i >= 0; i--) begin
      put(hex_char((i < 8) ? 4'((v >> (4 * i)) & 32'hf) : 4'h0), 1'b0);
    end
    if (with_cr) put(CharCr, 1'b0);
    put(CharLf, 1'b0);
  endtask

  task automatic put_payload(int unsigned n);
    for (int unsigned i = 0; i < n; i++) put(payload_byte(), 1'b0);
  endtask

  task automatic put_chunk(int unsigned n, int unsigned digits);
    put_size_line(n, digits, $urandom_range(0, 3) != 0);
    put_payload(n);
    put(CharCr, 1'b0);
    put(CharLf, 1'b0);
  endtask

  task automatic build_body();
    int unsigned n;
    int unsigned need;
    int unsigned digits;
    int unsigned pick;
    body_end_e   how;
    // longest legal line, payload extremes, lf alone as payload
    put_size_line(2, LineMax, 1'b1);
    put(8'h00, 1'b0);
    put(8'hff, 1'b0);
    put(CharCr, 1'b0);
    put(CharLf, 1'b0);
    put_size_line(1, 1, 1'b0);
    put(CharLf, 1'b0);
    put(CharCr, 1'b0);
    put(CharLf, 1'b0);
    // well-formed chunks with random sizes, padding and content
    while (body_q.size() < BodyBeats) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      need = 1;
      while ((n >> (4 * need)) != 0) need++;
      pick = $urandom_range(0, 7);
      if (pick == 0) digits = LineMax;
      else if (pick < 3) digits = need + $urandom_range(1, 3);
      else digits = need;
      put_chunk(n, digits);
    end
    how = body_end_e'($urandom_range(0, 10));
    case (how)
      EndZeroChunk:   put_size_line(0, 1, 1'b1);
      EndZeroPadded:  put_size_line(0, $urandom_range(2, LineMax), 1'b0);
      EndBadHex: begin
        put(hex_char(4'($urandom_range(1, 15))), 1'b0);
        put(non_hex_char(), 1'b0);
        put(CharCr, 1'b0);
        put(CharLf, 1'b0);
      end
      EndEmptyLine: begin
        if ($urandom_range(0, 1)) put(CharCr, 1'b0);
        put(CharLf, 1'b0);
      end
      EndOverflow: begin
        // one past the largest size that fits
        put("1", 1'b0);
        for (int i = 0; i < SizeBits / 4; i++) put("0", 1'b0);
        put(CharLf, 1'b0);
      end
      EndLongLine: for (int i = 0; i <= LineMax; i++) put(hex_char(4'h0), 1'b0);
      EndStrayCr: begin
        put("1", 1'b0);
        put(CharCr, 1'b0);
        put(hex_char(4'($urandom_range(0, 15))), 1'b0);
        put(CharLf, 1'b0);
      end
      EndMissingCrlf: begin
        put_size_line(2, 1, 1'b1);
        put_payload(2);
        if ($urandom_range(0, 1)) begin
          put(CharLf, 1'b0);
        end else begin
          put(CharCr, 1'b0);
          put(CharCr, 1'b0);
        end
      end
      EndCloseInLine: begin
        put("1", 1'b0);
        put(8'($urandom_range(0, 255)), 1'b1);
      end
      EndCloseInData: begin
        put_size_line(5, 1, 1'b1);
        put_payload(2);
        put(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        put_size_line(3, 1, 1'b0);
        put_payload(3);
        put(CharCr, 1'b0);
        put(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
    // beats after the body is over must keep giving the same answer
    for (int i = 0; i < 24; i++) put(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    logic offer;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.in_byte <= 8'h00;
      in_if.stream_end <= 1'b0;
    end else begin
      offer = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        result_q.push_back(decode_beat(cur_beat.in_byte, cur_beat.stream_end));
        sent_cnt++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (body_q.size() > 0) begin
          cur_beat = body_q.pop_front();
          in_if.in_byte <= cur_beat.in_byte;
          in_if.stream_end <= cur_beat.stream_end;
          offer = 1'b1;
          gap_left = (((sent_cnt / 256) % 3) == 1) ? 0 : $urandom_range(0, 5);
        end
      end
      in_if.valid <= offer;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    logic      rdy;
    out_beat_t exp_r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, got kind %0d byte %02h code %0d",
                   $time, out_if.kind, out_if.out_byte, out_if.error_code);
        end else begin
          exp_r = result_q.pop_front();
          if (out_if.kind !== exp_r.kind || out_if.out_byte !== exp_r.out_byte ||
              out_if.error_code !== exp_r.error_code) begin
            mismatches++;
            $display("%0t: beat %0d expected kind %0d byte %02h code %0d,",
                     $time, got_cnt, exp_r.kind, exp_r.out_byte, exp_r.error_code,
                     "  got kind %0d byte %02h code %0d",
                     out_if.kind, out_if.out_byte, out_if.error_code);
          end
        end
        got_cnt++;
        stall_left = (((got_cnt / 200) % 3) == 2) ? 0 : $urandom_range(0, 5);
        // one long hold-off so the decoder backs up into its input
        if (got_cnt == 150 && !held) begin
          hold_left = 120;
          held = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    build_body();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (body_q.size() != 0 || in_if.valid || result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
